FILE: src/piecewise_linear_interp_normal_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator checker
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERP_NORMAL_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERP_NORMAL_DEFINES_SVH

// Same-cycle implication
`define PLIN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PLIN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg
// Shared types, codes and helpers of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package plin_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int IDX_W          = 6;
  localparam int PCNT_W         = 7;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Q2.14 one
  localparam logic signed [15:0] NORM_ONE = 16'sd16384;

  typedef struct packed {
    logic                operation;
    logic [IDX_W-1:0]    point_index;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  query_x;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  value;
    logic signed [15:0]  normal_x;
    logic signed [15:0]  normal_y;
  } out_t;

  // Magnitude of a 33-bit signed value (fits 33 bits unsigned)
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // Saturate a 42-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sd2147483647;
    lo = -42'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: src/plin_ram.sv
// ----------------------------------------------------------------------------
// plin_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module plin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read of the contents before the write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/piecewise_linear_interp_normal.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp_normal
// Breakpoint table with linear interpolation and unit segment normal.
// ----------------------------------------------------------------------------
// A load request (operation 0) writes one breakpoint and gives no result;
// busy stays low. An evaluate request keeps busy high while it runs: a
// linear scan of the table through the RAM read port (one entry a cycle),
// a fetch of the segment ends and a setup step, then a bit-serial
// multiplier, a restoring divider and a square root unit run in turn for
// the interpolation, both squares, the length and both normal components.
// A query on the last breakpoint or a segment with equal abscissae skips
// the interpolation, a zero-length segment also skips the normal divides,
// and a query at or below the first breakpoint or beyond the last, or a
// single point in use, skips all of the arithmetic. The result shows for
// one cycle with out_valid, as busy falls, and must be taken then.
module piecewise_linear_interp_normal
  import plin_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [PCNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_FETCH, S_SETUP, S_LMUL, S_LDIV, S_NSTART,
    S_AMUL, S_BMUL, S_SQRT, S_NXDIV, S_NYDIV, S_DONE
  } state_t;

  state_t st_r;

  logic [PCNT_W-1:0]   pcnt_r;
  logic [NW-1:0]       n_r;
  logic signed [31:0]  q_r;
  logic [AW-1:0]       ia_r, rd_a_r, seg_r;
  logic                iss_done_r, rd_vld_r;
  logic [1:0]          fcnt_r;
  logic signed [31:0]  x0_r, y0_r, xl_r, yl_r, xa_r, ya_r, xb_r, yb_r;
  logic [6:0]          cnt_r;
  logic [65:0]         mul_acc_r, mul_cand_r;
  logic [32:0]         mul_plier_r;
  logic [32:0]         div_rem_r, div_den_r;
  logic [65:0]         div_num_r, div_quo_r;
  logic [63:0]         sq_v_r, sq_r_r, sq_bit_r, sqa_r;
  logic signed [31:0]  val_r;
  logic signed [15:0]  nx_r, ny_r;
  logic                out_valid_r;
  out_t                out_r;

  logic                accept, ld_ok;
  logic [AW-1:0]       ld_addr, nm1, ram_addr;
  logic [IDX_W+AW-1:0] idx_ext;
  logic [31:0]         rx, ry;
  logic [NW-1:0]       n_clamp;
  logic [31:0]         pc32;

  logic signed [32:0]  dx, dy, tq;
  logic [32:0]         mdx, mdy, mtq;
  logic [30:0]         ma_s, mb_s;
  logic                lneg;

  logic [65:0]         mul_acc_nxt;
  logic [33:0]         rem_sh;
  logic                div_bit;
  logic [32:0]         div_rem_nxt;
  logic [65:0]         div_quo_nxt;
  logic [63:0]         sq_t, sq_v_nxt, sq_r_nxt;
  logic [40:0]         lq;
  logic signed [41:0]  lsum;
  logic [14:0]         cq;

  assign busy      = (st_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Load address and range check
  assign idx_ext = {{AW{1'b0}}, in_data.point_index};
  assign ld_addr = idx_ext[AW-1:0];
  assign ld_ok   = accept && (in_data.operation == OP_LOAD) &&
                   (idx_ext < (IDX_W+AW)'(MAX_POINTS));

  // Points in use, clamped to 1..MAX_POINTS
  assign pc32 = {{(32-PCNT_W){1'b0}}, pcnt_r};
  always_comb begin
    if (pc32 == 32'd0) begin
      n_clamp = NW'(1);
    end else if (pc32 > 32'(MAX_POINTS)) begin
      n_clamp = NW'(MAX_POINTS);
    end else begin
      n_clamp = NW'(pc32);
    end
  end
  assign nm1 = AW'(n_r - NW'(1));

  // RAM port address
  always_comb begin
    ram_addr = ld_addr;
    if (st_r == S_SCAN) begin
      ram_addr = ia_r;
    end else if (st_r == S_FETCH) begin
      ram_addr = (fcnt_r == 2'd0) ? seg_r : AW'(seg_r + AW'(1));
    end
  end

  plin_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(ld_ok), .addr(ram_addr), .wdata(in_data.point_x), .rdata(rx)
  );
  plin_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(ld_ok), .addr(ram_addr), .wdata(in_data.point_y), .rdata(ry)
  );

  // Segment differences and normalized magnitudes
  always_comb begin
    dx   = {xb_r[31], xb_r} - {xa_r[31], xa_r};
    dy   = {yb_r[31], yb_r} - {ya_r[31], ya_r};
    tq   = {q_r[31], q_r} - {xa_r[31], xa_r};
    mdx  = mag33(dx);
    mdy  = mag33(dy);
    mtq  = mag33(tq);
    lneg = dy[32] ^ tq[32] ^ dx[32];
    if (mdy[32] || mdx[32]) begin
      ma_s = mdy[32:2];
      mb_s = mdx[32:2];
    end else if (mdy[31] || mdx[31]) begin
      ma_s = mdy[31:1];
      mb_s = mdx[31:1];
    end else begin
      ma_s = mdy[30:0];
      mb_s = mdx[30:0];
    end
  end

  // Shared shift-add multiply step
  assign mul_acc_nxt = mul_plier_r[0] ? mul_acc_r + mul_cand_r : mul_acc_r;

  // Shared restoring divide step
  always_comb begin
    rem_sh      = {div_rem_r, div_num_r[65]};
    div_bit     = (rem_sh >= {1'b0, div_den_r});
    div_rem_nxt = div_bit ? 33'(rem_sh - {1'b0, div_den_r}) : rem_sh[32:0];
    div_quo_nxt = {div_quo_r[64:0], div_bit};
  end

  // Square root step
  always_comb begin
    sq_t = sq_r_r + sq_bit_r;
    if (sq_v_r >= sq_t) begin
      sq_v_nxt = sq_v_r - sq_t;
      sq_r_nxt = (sq_r_r >> 1) + sq_bit_r;
    end else begin
      sq_v_nxt = sq_v_r;
      sq_r_nxt = sq_r_r >> 1;
    end
  end

  // Interpolation result from the quotient, and clamped normal component
  always_comb begin
    lq   = (div_quo_nxt > (66'd1 << 40)) ? (41'd1 << 40) : div_quo_nxt[40:0];
    lsum = lneg ? ({{10{ya_r[31]}}, ya_r} - {1'b0, lq})
                : ({{10{ya_r[31]}}, ya_r} + {1'b0, lq});
    cq   = (div_quo_nxt > 66'd16384) ? 15'd16384 : div_quo_nxt[14:0];
  end

  // Sequencer with datapath and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pcnt_r      <= PCNT_W'(1);
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      fcnt_r      <= 2'd0;
      cnt_r       <= 7'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        pcnt_r <= cfg_wdata;
      end
      unique case (st_r)
        S_IDLE: begin
          if (accept && (in_data.operation == OP_EVAL)) begin
            q_r        <= in_data.query_x;
            n_r        <= n_clamp;
            ia_r       <= '0;
            seg_r      <= '0;
            iss_done_r <= 1'b0;
            rd_vld_r   <= 1'b0;
            st_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, check the entry that comes back
          if (!iss_done_r) begin
            ia_r <= AW'(ia_r + AW'(1));
            if (ia_r == nm1) begin
              iss_done_r <= 1'b1;
            end
          end
          rd_vld_r <= !iss_done_r;
          rd_a_r   <= ia_r;
          if (rd_vld_r) begin
            if (rd_a_r == '0) begin
              x0_r <= rx;
              y0_r <= ry;
            end
            if (rd_a_r == nm1) begin
              xl_r <= rx;
              yl_r <= ry;
              if (n_r == NW'(1)) begin
                val_r <= ry;
                nx_r  <= '0;
                ny_r  <= NORM_ONE;
                st_r  <= S_DONE;
              end else begin
                fcnt_r <= 2'd0;
                st_r   <= S_FETCH;
              end
            end else if ($signed(rx) <= q_r) begin
              seg_r <= rd_a_r;
            end
          end
        end
        S_FETCH: begin
          // read both ends of the chosen segment
          fcnt_r <= fcnt_r + 2'd1;
          if (fcnt_r == 2'd1) begin
            xa_r <= rx;
            ya_r <= ry;
          end else if (fcnt_r == 2'd2) begin
            xb_r <= rx;
            yb_r <= ry;
            st_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (!(q_r > x0_r)) begin
            val_r <= y0_r;
            nx_r  <= '0;
            ny_r  <= NORM_ONE;
            st_r  <= S_DONE;
          end else if (q_r >= xl_r) begin
            val_r <= yl_r;
            if (q_r == xl_r) begin
              st_r <= S_NSTART;
            end else begin
              nx_r <= '0;
              ny_r <= NORM_ONE;
              st_r <= S_DONE;
            end
          end else if (dx == '0) begin
            val_r <= ya_r;
            st_r  <= S_NSTART;
          end else begin
            mul_acc_r   <= '0;
            mul_cand_r  <= {33'd0, mdy};
            mul_plier_r <= mtq;
            cnt_r       <= 7'd33;
            st_r        <= S_LMUL;
          end
        end
        S_LMUL: begin
          mul_acc_r   <= mul_acc_nxt;
          mul_cand_r  <= mul_cand_r << 1;
          mul_plier_r <= mul_plier_r >> 1;
          cnt_r       <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            div_num_r <= mul_acc_nxt;
            div_den_r <= mdx;
            div_rem_r <= '0;
            div_quo_r <= '0;
            cnt_r     <= 7'd66;
            st_r      <= S_LDIV;
          end
        end
        S_LDIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_num_r <= div_num_r << 1;
          cnt_r     <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            val_r <= sat32(lsum);
            st_r  <= S_NSTART;
          end
        end
        S_NSTART: begin
          mul_acc_r   <= '0;
          mul_cand_r  <= {35'd0, ma_s};
          mul_plier_r <= {2'd0, ma_s};
          cnt_r       <= 7'd33;
          st_r        <= S_AMUL;
        end
        S_AMUL: begin
          mul_acc_r   <= mul_acc_nxt;
          mul_cand_r  <= mul_cand_r << 1;
          mul_plier_r <= mul_plier_r >> 1;
          cnt_r       <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            sqa_r       <= mul_acc_nxt[63:0];
            mul_acc_r   <= '0;
            mul_cand_r  <= {35'd0, mb_s};
            mul_plier_r <= {2'd0, mb_s};
            cnt_r       <= 7'd33;
            st_r        <= S_BMUL;
          end
        end
        S_BMUL: begin
          mul_acc_r   <= mul_acc_nxt;
          mul_cand_r  <= mul_cand_r << 1;
          mul_plier_r <= mul_plier_r >> 1;
          cnt_r       <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            sq_v_r   <= sqa_r + mul_acc_nxt[63:0];
            sq_r_r   <= '0;
            sq_bit_r <= 64'd1 << 62;
            cnt_r    <= 7'd32;
            st_r     <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v_r   <= sq_v_nxt;
          sq_r_r   <= sq_r_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            if (sq_r_nxt == '0) begin
              // zero-length segment
              nx_r <= '0;
              ny_r <= NORM_ONE;
              st_r <= S_DONE;
            end else begin
              div_num_r <= {21'd0, ma_s, 14'd0};
              div_den_r <= sq_r_nxt[32:0];
              div_rem_r <= '0;
              div_quo_r <= '0;
              cnt_r     <= 7'd66;
              st_r      <= S_NXDIV;
            end
          end
        end
        S_NXDIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_num_r <= div_num_r << 1;
          cnt_r     <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            // sign of a = y0 - y1 is negative when dy is positive
            nx_r      <= (dy[32] == 1'b0 && dy != '0) ? -$signed({1'b0, cq})
                                                      : $signed({1'b0, cq});
            div_num_r <= {21'd0, mb_s, 14'd0};
            div_rem_r <= '0;
            div_quo_r <= '0;
            cnt_r     <= 7'd66;
            st_r      <= S_NYDIV;
          end
        end
        S_NYDIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_num_r <= div_num_r << 1;
          cnt_r     <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            ny_r <= dx[32] ? -$signed({1'b0, cq}) : $signed({1'b0, cq});
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r    <= 1'b1;
          out_r.value    <= val_r;
          out_r.normal_x <= nx_r;
          out_r.normal_y <= ny_r;
          st_r           <= S_IDLE;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/plin_checker.sv
// ----------------------------------------------------------------------------
// plin_checker
// Port-level checks of the piecewise linear interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interp_normal_defines.svh"

module plin_checker
  import plin_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input in_t               in_data,
  input logic              out_valid,
  input out_t              out_data
);

  logic eval_req, load_req, norm_ok;

  assign eval_req = start && !busy && (in_data.operation == OP_EVAL);
  assign load_req = start && !busy && (in_data.operation == OP_LOAD);

  // both normal components inside the Q2.14 unit range
  assign norm_ok = (out_data.normal_x <= NORM_ONE) && (out_data.normal_x >= -NORM_ONE) &&
                   (out_data.normal_y <= NORM_ONE) && (out_data.normal_y >= -NORM_ONE);

  // an evaluate request makes the block busy
  `PLIN_ASSERT_NEXT(a_eval_busy, eval_req, busy, "evaluate request did not raise busy")
  // a load request completes at once and gives no result
  `PLIN_ASSERT_NEXT(a_load_quiet, load_req, !busy && !out_valid, "load request misbehaved")
  // the result strobe lasts one cycle
  `PLIN_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid, "result strobe longer than one cycle")
  // a result ends the evaluation
  `PLIN_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  // normal components stay within the Q2.14 unit range
  `PLIN_ASSERT_NOW(a_norm_range, out_valid, norm_ok, "normal out of range")

endmodule

bind piecewise_linear_interp_normal plin_checker u_plin_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);

FILE: sim/piecewise_linear_interp_normal_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp_normal_tb
// Drives load and evaluate requests into the interpolator, predicts each
// evaluate result (clamped / interpolated value, unit normal) and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_interp_normal_tb;
  import plin_pkg::*;

  localparam int NPTS = 64;
  localparam int EVAL_LAT = 600;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_we;
  logic [PCNT_W-1:0] cfg_wdata;

  int err_count;
  bit idle_on;

  piecewise_linear_interp_normal DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Table shadow, point count and queue of expected evaluate results
  class interp_scoreboard;
    longint bx[NPTS];
    longint by[NPTS];
    int unsigned pcount;
    out_t pending[$];

    function void clear();
      foreach (bx[i]) begin
        bx[i] = 0;
        by[i] = 0;
      end
      pcount = 1;
    endfunction

    function longint magnitude(input longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint int_sqrt(input longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    // dy * t / dx with 128-bit product, quotient capped at 2^40
    function longint seg_interp(input longint q, input longint x0, input longint y0,
                                input longint x1, input longint y1);
      logic [127:0] prod;
      logic [127:0] quo;
      longint dx;
      longint dy;
      longint t;
      longint qv;
      longint r;
      bit neg;
      dx = x1 - x0;
      dy = y1 - y0;
      t = q - x0;
      if (dx == 0) return y0;
      prod = 128'(magnitude(dy)) * 128'(magnitude(t));
      quo = prod / 128'(magnitude(dx));
      qv = (quo > (128'd1 << 40)) ? (64'sd1 <<< 40) : longint'(quo[63:0]);
      neg = ((dy < 0) != (t < 0)) != (dx < 0);
      r = neg ? y0 - qv : y0 + qv;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    function void load_point(input in_t req);
      bx[req.point_index] = longint'(req.point_x);
      by[req.point_index] = longint'(req.point_y);
    endfunction

    function void note_request(input in_t req);
      int n;
      int seg;
      longint q;
      longint a;
      longint b;
      longint ma;
      longint mb;
      longint len;
      longint cx;
      longint cy;
      out_t res;
      if (req.operation == OP_LOAD) begin
        load_point(req);
        return;
      end
      n = pcount == 0 ? 1 : (pcount > NPTS ? NPTS : pcount);
      q = longint'(req.query_x);
      seg = 0;
      for (int i = 0; i + 1 < n; i++)
        if (bx[i] <= q) seg = i;
      if (n == 1 || q <= bx[0]) res.value = 32'(by[0]);
      else if (q >= bx[n-1]) res.value = 32'(by[n-1]);
      else res.value = 32'(seg_interp(q, bx[seg], by[seg], bx[seg+1], by[seg+1]));
      res.normal_x = '0;
      res.normal_y = NORM_ONE;
      if (n >= 2 && q > bx[0] && q <= bx[n-1]) begin
        a = by[seg] - by[seg+1];
        b = bx[seg+1] - bx[seg];
        ma = magnitude(a);
        mb = magnitude(b);
        while (ma >= (64'sd1 <<< 31) || mb >= (64'sd1 <<< 31)) begin
          ma = ma >>> 1;
          mb = mb >>> 1;
        end
        len = int_sqrt(ma * ma + mb * mb);
        if (len != 0) begin
          cx = ma * 16384 / len;
          cy = mb * 16384 / len;
          if (cx > 16384) cx = 16384;
          if (cy > 16384) cy = 16384;
          res.normal_x = 16'(a < 0 ? -cx : cx);
          res.normal_y = 16'(b < 0 ? -cy : cy);
        end
      end
      pending.push_back(res);
    endfunction

    task check_result(input out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result value", got.value, 0);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) report_mismatch("value", got.value, want.value);
      if (got.normal_x !== want.normal_x)
        report_mismatch("normal_x", got.normal_x, want.normal_x);
      if (got.normal_y !== want.normal_y)
        report_mismatch("normal_y", got.normal_y, want.normal_y);
    endtask
  endclass

  interp_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  task automatic random_gap();
    int g;
    if (idle_on && $urandom_range(3) == 0) begin
      g = $urandom_range(9, 1);
      repeat (g) @(negedge clk);
    end
  endtask

  // Present one request and hold it until accepted
  task automatic send_request(input in_t req);
    random_gap();
    in_data = req;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic load_point(input int idx, input logic [31:0] px, input logic [31:0] py);
    in_t r;
    r = '0;
    r.operation = OP_LOAD;
    r.point_index = IDX_W'(idx);
    r.point_x = px;
    r.point_y = py;
    send_request(r);
  endtask

  task automatic evaluate(input logic [31:0] q);
    in_t r;
    r.operation = OP_EVAL;
    r.point_index = IDX_W'($urandom);
    r.point_x = $urandom;
    r.point_y = $urandom;
    r.query_x = q;
    send_request(r);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (EVAL_LAT) @(negedge clk);
  endtask

  task automatic set_count(input int n);
    drain();
    cfg_wdata <= PCNT_W'(n);
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.pcount = n;
  endtask

  // Sorted random table of n points; step size picked by spread
  task automatic fill_table(input int n, input int spread);
    longint x;
    x = -64'sd2147483648 + $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      load_point(i, 32'(x), $urandom);
      x = x + 1 + $urandom_range(spread);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
    end
  endtask

  function automatic logic [31:0] pick_query(input int n);
    int k;
    k = $urandom_range(n - 1);
    case ($urandom_range(4))
      0: return 32'(sb.bx[k]);
      1: return 32'(sb.bx[k] + $signed($urandom_range(200)) - 100);
      2: return $urandom;
      default: return 32'(sb.bx[k] + $urandom_range(1 << 24));
    endcase
  endfunction

  initial begin
    int n;
    int issued;
    sb = new();
    sb.clear();
    err_count = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: single point, clamping, extremes, equal and unsorted abscissae
    load_point(0, 32'h8000_0000, 32'h7fff_ffff);
    evaluate(32'h7fff_ffff);
    evaluate(32'h8000_0000);
    load_point(1, 32'h7fff_ffff, 32'h8000_0000);
    set_count(2);
    evaluate(32'h0000_0000);
    evaluate(32'h7fff_ffff);
    evaluate(32'h8000_0000);
    evaluate(32'h8000_0001);
    load_point(1, 32'h8000_0000, 32'h0001_0000);
    evaluate(32'h0000_0000);
    load_point(0, 32'h0000_0000, 32'h0000_0000);
    load_point(1, 32'h0001_0000, 32'h0000_0000);
    load_point(2, 32'h0000_8000, 32'h0002_0000);
    set_count(3);
    evaluate(32'h0000_8000);
    evaluate(32'h0000_4000);
    evaluate(32'h0001_0000);
    load_point(2, 32'h0001_0000, 32'h0005_0000);
    evaluate(32'h0001_0000);
    set_count(0);
    evaluate(32'h1234_5678);
    set_count(127);
    fill_table(64, 1 << 26);
    evaluate(32'h7fff_ffff);
    set_count(64);
    evaluate(32'h0000_0000);

    // Random phases with varying point counts
    issued = 85;
    while (issued < 1450) begin
      if (issued > 1250) idle_on = 1'b0;
      case ($urandom_range(5))
        0: n = 64;
        1: n = 1;
        default: n = $urandom_range(16, 2);
      endcase
      set_count(n);
      fill_table(n, $urandom_range(1) ? (1 << 27) : 300);
      issued += n;
      repeat ($urandom_range(30, 5)) begin
        if ($urandom_range(15) == 0) begin
          load_point($urandom_range(n - 1), $urandom, $urandom);
        end else begin
          evaluate(pick_query(n));
        end
        issued++;
      end
      // now and then the sender waits out every outstanding result
      if ($urandom_range(3) == 0) while (sb.pending.size() != 0) @(negedge clk);
    end

    drain();
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("piecewise_linear_interp_normal_tb: clean");
    end else begin
      $display("piecewise_linear_interp_normal_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("piecewise_linear_interp_normal_tb: errors");
    $finish;
  end

endmodule
